// ----- sv/tea_pkg.sv -----
// TEA block cipher shared definitions: widths, round constants, block and key types.
// No dependencies; imported by every module of the cipher.
`timescale 1ns / 1ps

package tea_pkg;

   localparam int WORD_W    = 32;
   localparam int KEY_WORDS = 4;
   localparam int KEY_IDX_W = $clog2(KEY_WORDS);
   localparam int ROUNDS    = 32;
   localparam int STAGES    = 2 * ROUNDS;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = KEY_IDX_W'(0);
   localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = KEY_IDX_W'(1);
   localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = KEY_IDX_W'(2);
   localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = KEY_IDX_W'(3);

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_type;

   typedef struct packed {
      logic              op;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } blk_type;

   // Running sum of a round: delta*(r+1) going forward, delta*(ROUNDS-r) going back.
   function automatic logic [WORD_W-1:0] round_sum(input int unsigned rnd, input logic dec);
      logic [2*WORD_W-1:0] prod;
      if (dec) begin
         prod = TEA_DELTA * (2*WORD_W)'(ROUNDS - rnd);
      end else begin
         prod = TEA_DELTA * (2*WORD_W)'(rnd + 1);
      end
      return prod[WORD_W-1:0];
   endfunction

endpackage

// ----- sv/tea_half_round.sv -----
// One half-round pipeline stage of the TEA cipher, with its own valid bit.
// Depends on tea_pkg; instantiated twice per round by tea_block_cipher.
`timescale 1ns / 1ps

module tea_half_round
   import tea_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  key_type           key,
   input  logic [WORD_W-1:0] sum_enc,
   input  logic [WORD_W-1:0] sum_dec,
   input  logic              second_half,
   input  logic              in_valid,
   output logic              in_ready,
   input  blk_type           in_blk,
   output logic              out_valid,
   input  logic              out_ready,
   output blk_type           out_blk
);

   logic              valid_ff, valid_in;
   blk_type           blk_ff, blk_in;
   logic              update_y;
   logic              is_dec;
   logic [WORD_W-1:0] src, tgt, sum, ka, kb, mix, res;

   assign is_dec   = (in_blk.op == OP_DECRYPT);
   assign update_y = (is_dec == second_half);
   assign src      = update_y ? in_blk.z : in_blk.y;
   assign tgt      = update_y ? in_blk.y : in_blk.z;
   assign ka       = update_y ? key[KEY_IDX_0] : key[KEY_IDX_2];
   assign kb       = update_y ? key[KEY_IDX_1] : key[KEY_IDX_3];
   assign sum      = is_dec ? sum_dec : sum_enc;
   assign mix      = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
   assign res      = is_dec ? (tgt - mix) : (tgt + mix);

   always_comb begin
      blk_in    = in_blk;
      if (update_y) begin
         blk_in.y = res;
      end else begin
         blk_in.z = res;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> in_ready)
      else $error("empty stage refused a transaction");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("accepted transaction lost in stage");

endmodule

// ----- sv/tea_block_cipher.sv -----
// Top level of the TEA block cipher: key registers and the half-round pipeline.
// Depends on tea_pkg and tea_half_round.
`timescale 1ns / 1ps

// Usage:
//   req_* channel carries one 64-bit block (block_first, block_second) and the
//   operation bit (0 encrypt, 1 decrypt). rsp_* channel returns the processed
//   block. Both are valid/ready; a transaction moves when valid and ready are high.
//   csr_* writes one of the four 32-bit key words per cycle when csr_write_en is
//   high; write keys only while no transaction is in flight.
//   The cipher is unrolled into 64 half-round stages, one register each, so a
//   transaction is registered in each stage in turn and shows on rsp_valid from
//   the last; one block can be accepted every cycle unless the receiver stalls
//   with every stage full. Each stage holds its own valid bit; when the
//   receiver stalls, the stages behind the result fill up and empty stages
//   keep accepting, so bubbles close and nothing is dropped or repeated.
//   Reset clears all stage valid bits and the key words to zero.
module tea_block_cipher
   import tea_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [KEY_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [WORD_W-1:0]    req_block_first,
   input  logic [WORD_W-1:0]    req_block_second,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_W-1:0]    rsp_result_first,
   output logic [WORD_W-1:0]    rsp_result_second
);

   key_type key_ff, key_in;
   logic    [STAGES:0] stg_valid;
   logic    [STAGES:0] stg_ready;
   blk_type [STAGES:0] stg_blk;

   always_comb begin
      key_in = key_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            KEY_IDX_0: key_in[KEY_IDX_0] = csr_write_data;
            KEY_IDX_1: key_in[KEY_IDX_1] = csr_write_data;
            KEY_IDX_2: key_in[KEY_IDX_2] = csr_write_data;
            KEY_IDX_3: key_in[KEY_IDX_3] = csr_write_data;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign stg_valid[0]    = req_valid;
   assign req_ready       = stg_ready[0];
   assign stg_blk[0].op   = req_operation;
   assign stg_blk[0].y    = req_block_first;
   assign stg_blk[0].z    = req_block_second;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam logic [WORD_W-1:0] SUM_ENC = round_sum(s / 2, OP_ENCRYPT);
      localparam logic [WORD_W-1:0] SUM_DEC = round_sum(s / 2, OP_DECRYPT);
      localparam logic              SECOND  = ((s % 2) == 1);

      tea_half_round u_half (
         .clock       (clock),
         .reset       (reset),
         .key         (key_ff),
         .sum_enc     (SUM_ENC),
         .sum_dec     (SUM_DEC),
         .second_half (SECOND),
         .in_valid    (stg_valid[s]),
         .in_ready    (stg_ready[s]),
         .in_blk      (stg_blk[s]),
         .out_valid   (stg_valid[s+1]),
         .out_ready   (stg_ready[s+1]),
         .out_blk     (stg_blk[s+1])
      );
   end

   assign stg_ready[STAGES] = rsp_ready;
   assign rsp_valid         = stg_valid[STAGES];
   assign rsp_result_first  = stg_blk[STAGES].y;
   assign rsp_result_second = stg_blk[STAGES].z;

   a_drain_opens_input: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result presented right after reset");

endmodule
